@@ rtl/core/extended_gcd_bezout_assert.svh @@
// Assertion macros for the extended gcd block.
// Included by modules that check their own sequencing; needs no other file.
`ifndef EXTENDED_GCD_BEZOUT_ASSERT_SVH
`define EXTENDED_GCD_BEZOUT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EGCD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egcd assertion failed");

// Next-cycle implication, checked outside reset.
`define EGCD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egcd assertion failed");

`endif

@@ rtl/core/egcd_pkg.sv @@
// Shared types, constants and microcode table for the extended gcd block.
// Used by egcd_seq, egcd_dp and extended_gcd_bezout; depends on nothing.
package egcd_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int COEF_W       = OPERAND_BITS + 1;
  localparam int CNT_W        = $clog2(OPERAND_BITS);
  localparam int STEP_W       = 4;

  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_DIV_INIT = 4'd2;
  localparam logic [3:0] OP_DIV_STEP = 4'd3;
  localparam logic [3:0] OP_MUL_X    = 4'd4;
  localparam logic [3:0] OP_SUB_X    = 4'd5;
  localparam logic [3:0] OP_MUL_Y    = 4'd6;
  localparam logic [3:0] OP_SUB_Y    = 4'd7;
  localparam logic [3:0] OP_SHIFT_R  = 4'd8;
  localparam logic [3:0] OP_OUT      = 4'd9;

  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_IN    = 3'd2;
  localparam logic [2:0] COND_R_ZERO   = 3'd3;
  localparam logic [2:0] COND_DIV_MORE = 3'd4;
  localparam logic [2:0] COND_OUT_BUSY = 3'd5;

  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_TEST  = 4'd1;
  localparam logic [STEP_W-1:0] S_DIV   = 4'd2;
  localparam logic [STEP_W-1:0] S_MULX  = 4'd3;
  localparam logic [STEP_W-1:0] S_SUBX  = 4'd4;
  localparam logic [STEP_W-1:0] S_MULY  = 4'd5;
  localparam logic [STEP_W-1:0] S_SUBY  = 4'd6;
  localparam logic [STEP_W-1:0] S_SHIFT = 4'd7;
  localparam logic [STEP_W-1:0] S_OUT   = 4'd8;
  localparam logic [STEP_W-1:0] S_DONE  = 4'd9;

  typedef struct packed {
    logic              accept;
    logic [3:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic r_zero;
    logic div_more;
    logic out_busy;
  } stat_t;

  function automatic cw_t egcd_ucode(input logic [STEP_W-1:0] step);
    cw_t cw;
    unique case (step)
      S_IDLE:  cw = '{accept: 1'b1, op: OP_LOAD,     cond: COND_NO_IN,    target: S_IDLE};
      S_TEST:  cw = '{accept: 1'b0, op: OP_DIV_INIT, cond: COND_R_ZERO,   target: S_OUT};
      S_DIV:   cw = '{accept: 1'b0, op: OP_DIV_STEP, cond: COND_DIV_MORE, target: S_DIV};
      S_MULX:  cw = '{accept: 1'b0, op: OP_MUL_X,    cond: COND_NEVER,    target: S_IDLE};
      S_SUBX:  cw = '{accept: 1'b0, op: OP_SUB_X,    cond: COND_NEVER,    target: S_IDLE};
      S_MULY:  cw = '{accept: 1'b0, op: OP_MUL_Y,    cond: COND_NEVER,    target: S_IDLE};
      S_SUBY:  cw = '{accept: 1'b0, op: OP_SUB_Y,    cond: COND_NEVER,    target: S_IDLE};
      S_SHIFT: cw = '{accept: 1'b0, op: OP_SHIFT_R,  cond: COND_ALWAYS,   target: S_TEST};
      S_OUT:   cw = '{accept: 1'b0, op: OP_OUT,      cond: COND_OUT_BUSY, target: S_OUT};
      S_DONE:  cw = '{accept: 1'b0, op: OP_NOP,      cond: COND_ALWAYS,   target: S_IDLE};
      default: cw = '{accept: 1'b0, op: OP_NOP,      cond: COND_ALWAYS,   target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/core/egcd_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on egcd_pkg for the control word, status and step codes.
module egcd_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  egcd_pkg::stat_t stat,
  output egcd_pkg::cw_t   cw
);
  import egcd_pkg::*;

  logic [STEP_W-1:0] upc_r;
  logic [STEP_W-1:0] upc_nxt;
  logic              take;

  assign cw = egcd_ucode(upc_r);

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_IN:    take = !in_valid;
      COND_R_ZERO:   take = stat.r_zero;
      COND_DIV_MORE: take = stat.div_more;
      COND_OUT_BUSY: take = stat.out_busy;
      default:       take = 1'b1;
    endcase
    upc_nxt = take ? cw.target : upc_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ rtl/core/egcd_dp.sv @@
// Datapath: remainder and coefficient registers, bit-serial divider,
// shared multiplier and the output word register. Depends on egcd_pkg.
module egcd_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  egcd_pkg::cw_t                            cw,
  output egcd_pkg::stat_t                          stat,
  input  logic [egcd_pkg::OPERAND_BITS-1:0]        in_value_a,
  input  logic [egcd_pkg::OPERAND_BITS-1:0]        in_value_b,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [egcd_pkg::OPERAND_BITS-1:0]        out_divisor,
  output logic signed [egcd_pkg::COEF_W-1:0]       out_coeff_a,
  output logic signed [egcd_pkg::COEF_W-1:0]       out_coeff_b
);
  import egcd_pkg::*;
  `include "extended_gcd_bezout_assert.svh"

  localparam int N = OPERAND_BITS;

  logic [N-1:0]      prev_r_r, prev_r_nxt, cur_r_r, cur_r_nxt;
  logic [N-1:0]      rem_r, rem_nxt, quo_r, quo_nxt;
  logic [COEF_W-1:0] prev_x_r, prev_x_nxt, cur_x_r, cur_x_nxt;
  logic [COEF_W-1:0] prev_y_r, prev_y_nxt, cur_y_r, cur_y_nxt;
  logic [COEF_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [N-1:0]      odiv_r, odiv_nxt;
  logic [COEF_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [N:0]          trial, diff;
  logic                fits;
  logic [COEF_W-1:0]   mul_src;
  logic [2*COEF_W-1:0] mul_full;
  logic                out_busy;
  logic                load_out;

  assign out_busy = out_valid_r && out_stall;
  assign load_out = (cw.op == OP_OUT) && !out_busy;

  assign stat.r_zero   = (cur_r_r == '0);
  assign stat.div_more = (cnt_r != CNT_W'(N - 1));
  assign stat.out_busy = out_busy;

  assign trial    = {rem_r, quo_r[N-1]};
  assign diff     = trial - {1'b0, cur_r_r};
  assign fits     = (trial >= {1'b0, cur_r_r});
  assign mul_src  = (cw.op == OP_MUL_Y) ? cur_y_r : cur_x_r;
  assign mul_full = {1'b0, quo_r} * mul_src;

  always_comb begin
    prev_r_nxt = prev_r_r;
    cur_r_nxt  = cur_r_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    prev_x_nxt = prev_x_r;
    cur_x_nxt  = cur_x_r;
    prev_y_nxt = prev_y_r;
    cur_y_nxt  = cur_y_r;
    prod_nxt   = prod_r;
    unique case (cw.op)
      OP_NOP, OP_OUT: begin
      end
      OP_LOAD: begin
        prev_r_nxt = in_value_a;
        cur_r_nxt  = in_value_b;
        prev_x_nxt = COEF_W'(1);
        cur_x_nxt  = '0;
        prev_y_nxt = '0;
        cur_y_nxt  = COEF_W'(1);
      end
      OP_DIV_INIT: begin
        rem_nxt = '0;
        quo_nxt = prev_r_r;
        cnt_nxt = '0;
      end
      OP_DIV_STEP: begin
        rem_nxt = fits ? diff[N-1:0] : trial[N-1:0];
        quo_nxt = {quo_r[N-2:0], fits};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_MUL_X, OP_MUL_Y: begin
        prod_nxt = mul_full[COEF_W-1:0];
      end
      OP_SUB_X: begin
        prev_x_nxt = cur_x_r;
        cur_x_nxt  = prev_x_r - prod_r;
      end
      OP_SUB_Y: begin
        prev_y_nxt = cur_y_r;
        cur_y_nxt  = prev_y_r - prod_r;
      end
      OP_SHIFT_R: begin
        prev_r_nxt = cur_r_r;
        cur_r_nxt  = rem_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    odiv_nxt      = odiv_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      odiv_nxt      = prev_r_r;
      ox_nxt        = prev_x_r;
      oy_nxt        = prev_y_r;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prev_r_r <= prev_r_nxt;
    cur_r_r  <= cur_r_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    prev_x_r <= prev_x_nxt;
    cur_x_r  <= cur_x_nxt;
    prev_y_r <= prev_y_nxt;
    cur_y_r  <= cur_y_nxt;
    prod_r   <= prod_nxt;
    odiv_r   <= odiv_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = odiv_r;
  assign out_coeff_a = ox_r;
  assign out_coeff_b = oy_r;

  `EGCD_ASSERT_IMP(a_div_nonzero, clk, rst_n, cw.op == OP_DIV_STEP, cur_r_r != '0)
  `EGCD_ASSERT_IMP(a_rem_below, clk, rst_n, cw.op == OP_MUL_X, rem_r < cur_r_r)
  `EGCD_ASSERT_NXT(a_out_loaded, clk, rst_n, load_out, out_valid_r)

endmodule

@@ rtl/core/extended_gcd_bezout.sv @@
// Extended gcd block: takes two operands, returns gcd and Bezout coefficients.
// Top level; instantiates egcd_seq and egcd_dp, depends on egcd_pkg.
//
// Input channel: in_value_a, in_value_b with in_valid; the block drives
// in_stall, low only while the sequencer waits in its idle step.
// Result channel: out_divisor, out_coeff_a, out_coeff_b with out_valid;
// the receiver drives out_stall. One result word per input word.
// Each Euclid round runs one test step, 31 steps of the one-bit-per-cycle
// restoring divider, two multiply and subtract pairs on the shared
// multiplier and one remainder shift. When the test step finds a zero
// remainder, the result goes to the output register, and the sequencer
// then returns through its done step to idle to take the next word.
// Reset returns the sequencer to idle and drops out_valid.
// While the receiver stalls, the result holds in the output register, and
// a new result waits in the sequencer's output step; a finished result that
// has been loaded does not block the next input word.
module extended_gcd_bezout (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [egcd_pkg::OPERAND_BITS-1:0]        in_value_a,
  input  logic [egcd_pkg::OPERAND_BITS-1:0]        in_value_b,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [egcd_pkg::OPERAND_BITS-1:0]        out_divisor,
  output logic signed [egcd_pkg::COEF_W-1:0]       out_coeff_a,
  output logic signed [egcd_pkg::COEF_W-1:0]       out_coeff_b
);
  import egcd_pkg::*;

  cw_t   cw;
  stat_t stat;

  assign in_stall = !cw.accept;

  egcd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cw       (cw)
  );

  egcd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cw          (cw),
    .stat        (stat),
    .in_value_a  (in_value_a),
    .in_value_b  (in_value_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_divisor (out_divisor),
    .out_coeff_a (out_coeff_a),
    .out_coeff_b (out_coeff_b)
  );

endmodule
